>>> rtl/a2l_pkg.sv
`timescale 1ns / 1ps

package a2l_pkg;

   // default storage sizes
   localparam int unsigned RING_DEPTH_DEF  = 4096;
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // item kinds on the request channel
   localparam logic KIND_STREAM = 1'b0;
   localparam logic KIND_PULL   = 1'b1;

   // start code bytes
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] START_BYTE = 8'h01;

   // longest zero run held back from the ring
   localparam logic [1:0] ZRUN_MAX = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       is_prefix;
      logic       unit_last;
      logic       overflow_seen;
   } rsp_item_type;

   // source of the byte formed in the read stage
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_LEN_RAM,
      SEL_LEN_REG,
      SEL_PAYLOAD
   } sel_type;

endpackage

>>> rtl/a2l_stream_if.sv
`timescale 1ns / 1ps

interface a2l_stream_if #(
   parameter type item_type = logic
) ();
   logic     valid;
   logic     ready;
   item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/a2l_ram.sv
`timescale 1ns / 1ps

module a2l_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/annexb_to_length_prefixed_nal_unit.sv
`timescale 1ns / 1ps

// annex b byte stream to length-prefixed unit converter
//
// req_ch carries one item per handshake: a stream byte (kind 0, with an
// optional buffer_end mark) or a pull (kind 1). stream bytes give no result;
// every pull gives exactly one item on rsp_ch: a length prefix byte, a unit
// payload byte, or an empty item when no closed unit is waiting.
// unit bytes live in a ring ram, closed unit lengths in a small queue ram;
// both rams have a registered read and need no clearing pass.
// throughput: one item per cycle while rsp_ch does not stall. a stream byte
// that breaks a run of held zeros stores those zeros one per cycle through
// the single ring write port, and no new item is accepted until they are
// stored. a pull's result passes the read stage (ram read at the accepting
// edge) and then the output register before it is on rsp_ch.
// when rsp_ch stalls, one pull waits in the read stage and one in the output
// register; stream bytes and pulls stop being accepted only once both are
// full. synchronous reset empties ring, queue and pipeline and clears the
// sticky overflow flag.
module annexb_to_length_prefixed_nal_unit #(
   parameter int unsigned RING_DEPTH         = a2l_pkg::RING_DEPTH_DEF,
   parameter int unsigned LENGTH_QUEUE_DEPTH = a2l_pkg::QUEUE_DEPTH_DEF
) (
   input logic          clock,
   input logic          reset,
   a2l_stream_if.sink   req_ch,
   a2l_stream_if.source rsp_ch
);
   import a2l_pkg::*;

   localparam int unsigned AW  = $clog2(RING_DEPTH);
   localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
   localparam int unsigned CW1 = CW + 1;
   localparam int unsigned QAW = $clog2(LENGTH_QUEUE_DEPTH);
   localparam int unsigned QCW = $clog2(LENGTH_QUEUE_DEPTH + 1);
   localparam int unsigned XW  = 32 - CW;

   localparam logic [CW-1:0]  RD_C    = CW'(RING_DEPTH);
   localparam logic [CW:0]    RD_W    = CW1'(RING_DEPTH);
   localparam logic [AW-1:0]  WP_LAST = AW'(RING_DEPTH - 1);
   localparam logic [QAW-1:0] QP_LAST = QAW'(LENGTH_QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] QD_C    = QCW'(LENGTH_QUEUE_DEPTH);

   req_item_type req_item;

   // ring and queue control state
   logic [AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  olen_ff, olen_in;
   logic [CW-1:0]  bleft_ff, bleft_in;
   logic [1:0]     zrun_ff, zrun_in;
   logic [QAW-1:0] qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [QCW-1:0] qcount_ff, qcount_in;
   logic [2:0]     pidx_ff, pidx_in;
   logic           ovf_ff, ovf_in;

   // pending ring stores of a stream byte that flushes held zeros
   logic [2:0]     pend_rem_ff, pend_rem_in;
   logic [7:0]     pend_last_ff, pend_last_in;
   logic           pend_close_ff, pend_close_in;
   logic           busy;

   // read stage
   logic           s1_valid_ff, s1_valid_in;
   sel_type        s1_sel_ff, s1_sel_in;
   logic [1:0]     s1_pos_ff, s1_pos_in;
   logic           s1_last_ff, s1_last_in;
   logic           s1_ovf_ff, s1_ovf_in;
   logic           s1_adv, s1_free;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   // handshakes
   logic           req_acc, str_acc, pull_acc;

   // stream byte decode
   logic [2:0]     dec_n;
   logic [7:0]     dec_last;
   logic           dec_close;
   logic [1:0]     dec_zrun;
   logic [1:0]     zrun_inc;

   // one store-and-close step
   logic           step_go;
   logic [2:0]     rem;
   logic [7:0]     rem_last;
   logic           rem_close;
   logic           st_en, cl_en, room, store_ok;
   logic [7:0]     st_byte;
   logic [CW-1:0]  len1;
   logic           q_full;
   logic [AW-1:0]  wp_inc, wp_rew;
   logic [CW:0]    wp_wide;

   // pull side
   logic           pop, rd_ok, ring_re;
   logic [CW-1:0]  bleft_dec, fill_dec;
   logic [AW-1:0]  rp_inc;
   logic [QAW-1:0] qhead_inc, qtail_inc;

   // ram ports
   logic           ring_we, q_we;
   logic [7:0]     ring_rdata;
   logic [CW-1:0]  q_rdata;
   logic [31:0]    len_word_ram, len_word_reg;

   assign req_item = req_ch.payload;
   assign busy     = (pend_rem_ff != 3'd0);
   assign s1_adv   = !rsp_valid_ff || rsp_ch.ready;
   assign s1_free  = !s1_valid_ff || s1_adv;

   assign req_ch.ready = !reset && !busy && s1_free;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign str_acc      = req_acc && (req_item.kind == KIND_STREAM);
   assign pull_acc     = req_acc && (req_item.kind == KIND_PULL);

   // start code scan: how many ring stores this byte causes (held zeros
   // first, then the byte itself) and whether the open unit closes
   assign zrun_inc = zrun_ff + 2'd1;

   always_comb begin
      dec_n     = 3'd0;
      dec_last  = ZERO_BYTE;
      dec_close = req_item.buffer_end;
      dec_zrun  = 2'd0;
      if (req_item.data_byte == ZERO_BYTE) begin
         if (zrun_ff == ZRUN_MAX) begin
            // fourth zero and beyond belong to the unit
            dec_n    = req_item.buffer_end ? 3'd4 : 3'd1;
            dec_zrun = req_item.buffer_end ? 2'd0 : ZRUN_MAX;
         end else begin
            dec_n    = req_item.buffer_end ? {1'b0, zrun_inc} : 3'd0;
            dec_zrun = req_item.buffer_end ? 2'd0 : zrun_inc;
         end
      end else if (req_item.data_byte == START_BYTE && zrun_ff >= 2'd2) begin
         // start code: held zeros vanish, open unit closes
         dec_close = 1'b1;
      end else begin
         dec_n    = {1'b0, zrun_ff} + 3'd1;
         dec_last = req_item.data_byte;
      end
   end

   // step operands: fresh from the item or from the pending stores
   assign step_go   = busy || str_acc;
   assign rem       = busy ? pend_rem_ff   : dec_n;
   assign rem_last  = busy ? pend_last_ff  : dec_last;
   assign rem_close = busy ? pend_close_ff : dec_close;

   assign st_en    = (rem != 3'd0);
   assign st_byte  = (rem == 3'd1) ? rem_last : ZERO_BYTE;
   assign cl_en    = rem_close && (rem <= 3'd1);
   assign room     = (fill_ff < RD_C);
   assign store_ok = st_en && room;
   assign len1     = olen_ff + CW'(store_ok);
   assign q_full   = (qcount_ff == QD_C);

   assign wp_inc  = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);
   assign rp_inc  = (rp_ff == WP_LAST) ? '0 : rp_ff + AW'(1);
   assign qhead_inc = (qhead_ff == QP_LAST) ? '0 : qhead_ff + QAW'(1);
   assign qtail_inc = (qtail_ff == QP_LAST) ? '0 : qtail_ff + QAW'(1);

   // dropping a unit rewinds the write pointer by the unit length; a byte
   // stored in the same step cancels out, so the old pointer and length serve
   assign wp_wide = CW1'(wp_ff);
   assign wp_rew  = (wp_wide >= CW1'(olen_ff)) ? AW'(wp_wide - CW1'(olen_ff))
                                               : AW'(wp_wide + RD_W - CW1'(olen_ff));

   assign ring_we = step_go && store_ok;
   assign q_we    = step_go && cl_en && (len1 != '0) && !q_full;

   assign pop       = (pidx_ff == 3'd0) && (qcount_ff != '0);
   assign rd_ok     = (pidx_ff >= 3'd4) && (bleft_ff != '0) && (fill_ff != '0);
   assign ring_re   = pull_acc && rd_ok;
   assign bleft_dec = bleft_ff - CW'(rd_ok);
   assign fill_dec  = fill_ff - CW'(rd_ok);

   always_comb begin
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      fill_in       = fill_ff;
      olen_in       = olen_ff;
      bleft_in      = bleft_ff;
      zrun_in       = zrun_ff;
      qhead_in      = qhead_ff;
      qtail_in      = qtail_ff;
      qcount_in     = qcount_ff;
      pidx_in       = pidx_ff;
      ovf_in        = ovf_ff;
      pend_rem_in   = pend_rem_ff;
      pend_last_in  = pend_last_ff;
      pend_close_in = pend_close_ff;
      s1_sel_in     = SEL_NONE;
      s1_pos_in     = 2'd0;
      s1_last_in    = 1'b0;

      if (step_go) begin
         if (str_acc) begin
            zrun_in = dec_zrun;
         end
         pend_rem_in   = st_en ? rem - 3'd1 : 3'd0;
         pend_last_in  = rem_last;
         pend_close_in = rem_close;
         if (st_en && !room) begin
            ovf_in = 1'b1;
         end
         if (store_ok) begin
            wp_in   = wp_inc;
            fill_in = fill_ff + CW'(1);
         end
         olen_in = len1;
         if (cl_en) begin
            olen_in = '0;
            if (len1 != '0) begin
               if (q_full) begin
                  ovf_in  = 1'b1;
                  wp_in   = wp_rew;
                  fill_in = fill_ff - olen_ff;
               end else begin
                  qtail_in  = qtail_inc;
                  qcount_in = qcount_ff + QCW'(1);
               end
            end
         end
      end else if (pull_acc) begin
         if (pidx_ff == 3'd0) begin
            if (pop) begin
               // length leaves the queue with its first prefix byte
               qhead_in  = qhead_inc;
               qcount_in = qcount_ff - QCW'(1);
               pidx_in   = 3'd1;
               s1_sel_in = SEL_LEN_RAM;
               s1_pos_in = 2'd3;
            end
         end else if (pidx_ff <= 3'd3) begin
            pidx_in   = pidx_ff + 3'd1;
            s1_sel_in = SEL_LEN_REG;
            s1_pos_in = 2'(3'd3 - pidx_ff);
         end else begin
            if (rd_ok) begin
               rp_in     = rp_inc;
               fill_in   = fill_dec;
               bleft_in  = bleft_dec;
               s1_sel_in = SEL_PAYLOAD;
            end
            if (bleft_dec == '0 || fill_dec == '0) begin
               s1_last_in = rd_ok;
               bleft_in   = '0;
               pidx_in    = 3'd0;
            end
         end
      end

      // unit length arrives from the queue ram as its first byte leaves
      if (s1_valid_ff && s1_adv && s1_sel_ff == SEL_LEN_RAM) begin
         bleft_in = q_rdata;
      end
   end

   // read stage capture
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ovf_in   = s1_ovf_ff;
      if (s1_free) begin
         s1_valid_in = pull_acc;
         s1_ovf_in   = ovf_ff;
      end
   end

   // result formation from ram data or the held length
   assign len_word_ram = {{XW{1'b0}}, q_rdata};
   assign len_word_reg = {{XW{1'b0}}, bleft_ff};

   always_comb begin
      rsp_item_in               = '0;
      rsp_item_in.overflow_seen = s1_ovf_ff;
      case (s1_sel_ff)
         SEL_LEN_RAM: begin
            rsp_item_in.out_byte  = len_word_ram[8*s1_pos_ff +: 8];
            rsp_item_in.out_valid = 1'b1;
            rsp_item_in.is_prefix = 1'b1;
         end
         SEL_LEN_REG: begin
            rsp_item_in.out_byte  = len_word_reg[8*s1_pos_ff +: 8];
            rsp_item_in.out_valid = 1'b1;
            rsp_item_in.is_prefix = 1'b1;
         end
         SEL_PAYLOAD: begin
            rsp_item_in.out_byte  = ring_rdata;
            rsp_item_in.out_valid = 1'b1;
            rsp_item_in.unit_last = s1_last_ff;
         end
         default: begin
            rsp_item_in.out_byte = ZERO_BYTE;
         end
      endcase
   end

   assign rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         rp_ff         <= '0;
         fill_ff       <= '0;
         olen_ff       <= '0;
         bleft_ff      <= '0;
         zrun_ff       <= '0;
         qhead_ff      <= '0;
         qtail_ff      <= '0;
         qcount_ff     <= '0;
         pidx_ff       <= '0;
         ovf_ff        <= 1'b0;
         pend_rem_ff   <= '0;
         pend_close_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s1_sel_ff     <= SEL_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         fill_ff       <= fill_in;
         olen_ff       <= olen_in;
         bleft_ff      <= bleft_in;
         zrun_ff       <= zrun_in;
         qhead_ff      <= qhead_in;
         qtail_ff      <= qtail_in;
         qcount_ff     <= qcount_in;
         pidx_ff       <= pidx_in;
         ovf_ff        <= ovf_in;
         pend_rem_ff   <= pend_rem_in;
         pend_close_ff <= pend_close_in;
         s1_valid_ff   <= s1_valid_in;
         if (s1_free) begin
            s1_sel_ff <= s1_sel_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      s1_ovf_ff    <= s1_ovf_in;
      if (s1_free) begin
         s1_pos_ff  <= s1_pos_in;
         s1_last_ff <= s1_last_in;
      end
      if (s1_adv) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

   // unit byte ring
   a2l_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (st_byte),
      .rd_en   (ring_re),
      .rd_addr (rp_ff),
      .rd_data (ring_rdata)
   );

   // closed unit lengths
   a2l_ram #(
      .WIDTH (CW),
      .DEPTH (LENGTH_QUEUE_DEPTH)
   ) u_len_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (qtail_ff),
      .wr_data (len1),
      .rd_en   (pull_acc && pop),
      .rd_addr (qhead_ff),
      .rd_data (q_rdata)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= RD_C)
      else $error("ring fill above ring depth");

   a_ring_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wp_ff == rp_ff))
      else $error("empty ring with unequal pointers");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= QD_C)
      else $error("length queue count above depth");

   a_queue_ptrs: assert property (@(posedge clock) disable iff (reset)
      (qcount_ff == '0 || qcount_ff == QD_C) |-> (qhead_ff == qtail_ff))
      else $error("length queue pointers disagree with count");

   a_pull_in_stage: assert property (@(posedge clock) disable iff (reset)
      pull_acc |=> s1_valid_ff)
      else $error("accepted pull missing from read stage");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

endmodule
